// ===== rtl/core/rpy_pkg.sv =====
// Shared types, constants and the arctangent table of the roll/pitch/yaw core.
`timescale 1ns / 1ps

package rpy_pkg;

    localparam int ROT_W     = 16;
    localparam int TRANS_W   = 32;
    localparam int TOL_W     = 15;
    localparam int ANG_W     = 16;
    localparam int PITCH_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 9 * ROT_W + 3 * TRANS_W;
    localparam int M_DATA_W  = 144;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int CW            = 34;
    localparam int ZW            = 28;

    localparam int RAD_W     = 57;
    localparam int ROOT_W    = 29;
    localparam int ISQ_W     = 58;
    localparam int ISQ_STEPS = 29;

    localparam int PREP_LAT = 3;
    localparam int RIG_LAT  = 6;
    localparam int COR_LAT  = CORDIC_ITERS + 2;
    localparam int CORE_LAT = PREP_LAT + ISQ_STEPS + COR_LAT;

    localparam int HALF_PI_Q24 = 26353589;
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int ONE_Q14     = 16384;

    localparam logic [CFG_IDX_W-1:0] REG_DET_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORTHO_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GIMBAL_THR = 2'd2;

    typedef logic signed [ROT_W-1:0] rot_word_t;
    typedef logic signed [CW-1:0]    cvec_t;
    typedef logic signed [ZW-1:0]    angle_acc_t;

    typedef struct packed {
        logic [TOL_W-1:0] det_tol;
        logic [TOL_W-1:0] ortho_tol;
    } rig_cfg_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] pitch_s;
        logic signed [ROT_W:0]   roll_y;
        logic signed [ROT_W:0]   roll_x;
        logic signed [ROT_W:0]   yaw_y;
        logic signed [ROT_W:0]   yaw_x;
        logic                    gimbal;
    } side_t;

    // arctangent of 2^-i in Q4.24
    function automatic angle_acc_t atan_entry(input int idx);
        angle_acc_t val;
        unique case (idx)
            0:       val = 28'sd13176795;
            1:       val = 28'sd7778716;
            2:       val = 28'sd4110060;
            3:       val = 28'sd2086331;
            4:       val = 28'sd1047214;
            5:       val = 28'sd524117;
            6:       val = 28'sd262123;
            7:       val = 28'sd131069;
            8:       val = 28'sd65536;
            9:       val = 28'sd32768;
            10:      val = 28'sd16384;
            11:      val = 28'sd8192;
            12:      val = 28'sd4096;
            13:      val = 28'sd2048;
            14:      val = 28'sd1024;
            15:      val = 28'sd512;
            16:      val = 28'sd256;
            17:      val = 28'sd128;
            18:      val = 28'sd64;
            19:      val = 28'sd32;
            20:      val = 28'sd16;
            21:      val = 28'sd8;
            22:      val = 28'sd4;
            23:      val = 28'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/rpy_rigid_check.sv =====
// Pipelined determinant and orthogonality test of the rotation matrix.
`timescale 1ns / 1ps

module rpy_rigid_check (
    input  logic              clk,
    input  logic              en,
    input  rpy_pkg::rot_word_t rot [9],
    input  rpy_pkg::rig_cfg_t  cfg,
    output logic              rigid
);
    import rpy_pkg::*;

    localparam int GA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int GB [6] = '{0, 1, 2, 1, 2, 2};

    logic signed [31:0]    cof_prod_reg [6];
    logic signed [31:0]    gram_prod_reg [6][3];
    rot_word_t             row0_s1_reg [3];
    rot_word_t             row0_s2_reg [3];
    logic signed [32:0]    cof_reg [3];
    logic signed [33:0]    gram_reg [6];
    logic signed [48:0]    dterm_reg [3];
    logic [33:0]           mag_reg [6];
    logic signed [51:0]    det_reg;
    logic [59:0]           sq_reg [6];
    logic                  big_s4_reg;
    logic [51:0]           det_mag_reg;
    logic [61:0]           diag_sum_reg;
    logic [61:0]           off_sum_reg;
    logic                  big_s5_reg;
    logic                  rigid_reg;
    logic signed [52:0]    dev;
    logic [63:0]           frob;

    // stage 1: cofactor and Gram products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cof_prod_reg[0] <= 32'(rot[4]) * 32'(rot[8]);
            cof_prod_reg[1] <= 32'(rot[5]) * 32'(rot[7]);
            cof_prod_reg[2] <= 32'(rot[3]) * 32'(rot[8]);
            cof_prod_reg[3] <= 32'(rot[5]) * 32'(rot[6]);
            cof_prod_reg[4] <= 32'(rot[3]) * 32'(rot[7]);
            cof_prod_reg[5] <= 32'(rot[4]) * 32'(rot[6]);
            for (int p = 0; p < 6; p++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    gram_prod_reg[p][k] <= 32'(rot[k*3 + GA[p]]) * 32'(rot[k*3 + GB[p]]);
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                row0_s1_reg[j] <= rot[j];
            end
        end
    end

    // stage 2: cofactors and Gram entries less identity
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cof_reg[j]     <= 33'(cof_prod_reg[2*j]) - 33'(cof_prod_reg[2*j + 1]);
                row0_s2_reg[j] <= row0_s1_reg[j];
            end
            for (int p = 0; p < 6; p++)
            begin
                gram_reg[p] <= 34'(gram_prod_reg[p][0]) + 34'(gram_prod_reg[p][1])
                             + 34'(gram_prod_reg[p][2])
                             - ((p < 3) ? 34'sd268435456 : 34'sd0);
            end
        end
    end

    // stage 3: determinant terms and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dterm_reg[j] <= 49'(row0_s2_reg[j]) * 49'(cof_reg[j]);
            end
            for (int p = 0; p < 6; p++)
            begin
                mag_reg[p] <= gram_reg[p][33] ? 34'(-gram_reg[p]) : 34'(gram_reg[p]);
            end
        end
    end

    // stage 4: determinant sum and squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg    <= 52'(dterm_reg[0]) - 52'(dterm_reg[1]) + 52'(dterm_reg[2]);
            big_s4_reg <= 1'b0;
            for (int p = 0; p < 6; p++)
            begin
                sq_reg[p] <= 60'(mag_reg[p][29:0]) * 60'(mag_reg[p][29:0]);
                if (mag_reg[p][33:30] != 4'd0)
                begin
                    big_s4_reg <= 1'b1;
                end
            end
        end
    end

    assign dev = 53'(det_reg) - 53'sd4398046511104;

    // stage 5: deviation magnitude and partial norm sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_mag_reg  <= dev[52] ? 52'(-dev) : 52'(dev);
            diag_sum_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            off_sum_reg  <= 62'(sq_reg[3]) + 62'(sq_reg[4]) + 62'(sq_reg[5]);
            big_s5_reg   <= big_s4_reg;
        end
    end

    // off-diagonal entries count twice in the full norm
    assign frob = 64'(diag_sum_reg) + 64'({off_sum_reg, 1'b0});

    // stage 6: compare against tolerances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rigid_reg <= !big_s5_reg
                      && (det_mag_reg <= 52'({cfg.det_tol, 28'b0}))
                      && (frob <= 64'({cfg.ortho_tol, 42'b0}));
        end
    end

    assign rigid = rigid_reg;

endmodule

// ===== rtl/core/rpy_isqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
`timescale 1ns / 1ps

module rpy_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [rpy_pkg::RAD_W-1:0]  radicand,
    output logic [rpy_pkg::ROOT_W-1:0] root
);
    import rpy_pkg::*;

    logic [ISQ_W-1:0] n_reg [ISQ_STEPS];
    logic [ISQ_W-1:0] r_reg [ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_step
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [ISQ_W-1:0] n_prev;
        logic [ISQ_W-1:0] r_prev;
        logic [ISQ_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_prev = ISQ_W'(radicand);
            assign r_prev = '0;
        end
        else
        begin : g_next
            assign n_prev = n_reg[k-1];
            assign r_prev = r_reg[k-1];
        end

        assign trial = r_prev + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_prev >= trial)
                begin
                    n_reg[k] <= n_prev - trial;
                    r_reg[k] <= (r_prev >> 1) + BIT;
                end
                else
                begin
                    n_reg[k] <= n_prev;
                    r_reg[k] <= r_prev >> 1;
                end
            end
        end
    end

    assign root = r_reg[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/rpy_cordic.sv =====
// Pipelined vectoring CORDIC arctangent with rounding to Q3.13.
`timescale 1ns / 1ps

module rpy_cordic (
    input  logic                             clk,
    input  logic                             en,
    input  logic                             half_lim,
    input  rpy_pkg::cvec_t                   y_in,
    input  rpy_pkg::cvec_t                   x_in,
    output logic signed [rpy_pkg::ANG_W-1:0] angle
);
    import rpy_pkg::*;

    cvec_t      x_reg [CORDIC_ITERS+1];
    cvec_t      y_reg [CORDIC_ITERS+1];
    angle_acc_t z_reg [CORDIC_ITERS+1];
    logic       zero_reg [CORDIC_ITERS+1];
    cvec_t      x_pre;
    cvec_t      y_pre;
    angle_acc_t z_pre;
    angle_acc_t z_fin;
    angle_acc_t rnd;
    angle_acc_t lim;
    logic signed [ANG_W-1:0] angle_reg;

    // fold the left half plane into the right one
    always_comb
    begin
        x_pre = x_in;
        y_pre = y_in;
        z_pre = '0;
        if (x_in[CW-1])
        begin
            if (!y_in[CW-1])
            begin
                x_pre = y_in;
                y_pre = -x_in;
                z_pre = ZW'(HALF_PI_Q24);
            end
            else
            begin
                x_pre = -y_in;
                y_pre = x_in;
                z_pre = -ZW'(HALF_PI_Q24);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            z_reg[0]    <= z_pre;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 1; k <= CORDIC_ITERS; k++)
    begin : g_iter
        cvec_t dx;
        cvec_t dy;
        assign dx = y_reg[k-1] >>> (k - 1);
        assign dy = x_reg[k-1] >>> (k - 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k] <= zero_reg[k-1];
                if (!y_reg[k-1][CW-1])
                begin
                    x_reg[k] <= x_reg[k-1] + dx;
                    y_reg[k] <= y_reg[k-1] - dy;
                    z_reg[k] <= z_reg[k-1] + atan_entry(k - 1);
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] - dx;
                    y_reg[k] <= y_reg[k-1] + dy;
                    z_reg[k] <= z_reg[k-1] - atan_entry(k - 1);
                end
            end
        end
    end

    // round half up from Q4.24 to Q3.13 and clamp
    assign z_fin = zero_reg[CORDIC_ITERS] ? '0 : z_reg[CORDIC_ITERS];
    assign rnd   = (z_fin + ZW'(1024)) >>> 11;
    assign lim   = half_lim ? ZW'(HALF_PI_Q13) : ZW'(PI_Q13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rnd > lim)
            begin
                angle_reg <= lim[ANG_W-1:0];
            end
            else if (rnd < -lim)
            begin
                angle_reg <= ANG_W'(-lim);
            end
            else
            begin
                angle_reg <= rnd[ANG_W-1:0];
            end
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/core/rotation_to_roll_pitch_yaw_core.sv =====
// Top level: rigid pose to Z-Y-X Euler angles, fully pipelined.
//
// Slave stream: one pose per transfer on s_tdata (nine Q2.14 matrix entries,
// then translation x, y, z). Master stream: roll and yaw in Q3.13, pitch in
// Q2.13 radians, and the translation on m_tdata, m_tuser set when the matrix
// fails the rigidity test (angles are then zero).
// Configuration channel: cfg_index selects det_tolerance (0),
// ortho_tolerance_sq (1) or gimbal_threshold (2); other indexes are ignored.
// Write it only while no pose is in flight.
// Depth: 51 register stages (3 preparation, 29 square-root, 18 CORDIC and
// the output register). Throughput: one pose per cycle while no result waits
// with m_tready low, set by the single shared pipeline enable; every stage
// is a register.
// Stall: while a result waits with m_tready low the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset: clears all valid bits and loads the register defaults (2, 2, 1).
`timescale 1ns / 1ps

module rotation_to_roll_pitch_yaw_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    // trans_x_in, trans_y_in, trans_z_in
    input  logic [rpy_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // roll_angle, pitch_angle, yaw_angle, trans_x_out, trans_y_out,
    // trans_z_out, one zero pad bit
    output logic [rpy_pkg::M_DATA_W-1:0]        m_tdata,
    // status
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpy_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpy_pkg::TOL_W-1:0]           cfg_data
);
    import rpy_pkg::*;

    logic              en;
    logic              valid_reg [CORE_LAT+1];
    logic [TOL_W-1:0]  det_tol_reg;
    logic [TOL_W-1:0]  ortho_tol_reg;
    logic [TOL_W-1:0]  gimbal_thr_reg;
    rig_cfg_t          rcfg;
    rot_word_t         rot [9];
    logic              rigid;

    logic signed [ROT_W-1:0] pitch_s1_reg;
    logic signed [ROT_W-1:0] pitch_s2_reg;
    logic [29:0]             thr_sq_reg;
    rot_word_t               op_s1_reg [6];
    rot_word_t               op_s2_reg [6];
    logic [28:0]             s_sq_reg;
    logic signed [ROT_W:0]   neg_r20;
    logic [28:0]             rem;
    logic                    gimbal_next;
    logic [RAD_W-1:0]        radicand_reg;
    side_t                   side_next;
    side_t                   side_dly_reg [ISQ_STEPS+1];
    side_t                   sd;
    logic [ROOT_W-1:0]       root;
    logic                    gim_dly_reg [COR_LAT];
    logic                    rig_dly_reg [CORE_LAT-RIG_LAT];
    logic [3*TRANS_W-1:0]    tr_dly_reg [CORE_LAT];
    logic signed [ANG_W-1:0] roll_c;
    logic signed [ANG_W-1:0] pitch_c;
    logic signed [ANG_W-1:0] yaw_c;
    logic signed [ANG_W-1:0]   roll_out_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic signed [ANG_W-1:0]   yaw_out_reg;
    logic [3*TRANS_W-1:0]      tr_out_reg;
    logic                      status_out_reg;
    logic                      rig_last;
    logic                      gim_last;

    assign m_tvalid  = valid_reg[CORE_LAT];
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_tol_reg    <= TOL_W'(2);
            ortho_tol_reg  <= TOL_W'(2);
            gimbal_thr_reg <= TOL_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DET_TOL:    det_tol_reg    <= cfg_data;
                REG_ORTHO_TOL:  ortho_tol_reg  <= cfg_data;
                REG_GIMBAL_THR: gimbal_thr_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign rcfg = '{det_tol: det_tol_reg, ortho_tol: ortho_tol_reg};

    // valid bits advance with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i <= CORE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            rot[i] = s_tdata[i*ROT_W +: ROT_W];
        end
    end

    rpy_rigid_check u_rigid (
        .clk   (clk),
        .en    (en),
        .rot   (rot),
        .cfg   (rcfg),
        .rigid (rigid)
    );

    assign neg_r20 = -17'(rot[6]);

    // preparation: sine of pitch, its square, the radicand and the branch
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_r20 > 17'sd16384)
            begin
                pitch_s1_reg <= ROT_W'(ONE_Q14);
            end
            else if (neg_r20 < -17'sd16384)
            begin
                pitch_s1_reg <= -ROT_W'(ONE_Q14);
            end
            else
            begin
                pitch_s1_reg <= neg_r20[ROT_W-1:0];
            end
            thr_sq_reg   <= 30'(gimbal_thr_reg) * 30'(gimbal_thr_reg);
            op_s1_reg[0] <= rot[7];
            op_s1_reg[1] <= rot[8];
            op_s1_reg[2] <= rot[3];
            op_s1_reg[3] <= rot[0];
            op_s1_reg[4] <= rot[1];
            op_s1_reg[5] <= rot[4];
            s_sq_reg     <= 29'(32'(pitch_s1_reg) * 32'(pitch_s1_reg));
            pitch_s2_reg <= pitch_s1_reg;
            op_s2_reg    <= op_s1_reg;
            radicand_reg <= {rem, 28'b0};
        end
    end

    assign rem         = 29'd268435456 - s_sq_reg;
    assign gimbal_next = !(30'(rem) > thr_sq_reg);

    always_comb
    begin
        side_next.pitch_s = pitch_s2_reg;
        side_next.roll_y  = 17'(op_s2_reg[0]);
        side_next.roll_x  = 17'(op_s2_reg[1]);
        side_next.gimbal  = gimbal_next;
        if (gimbal_next)
        begin
            side_next.yaw_y = -17'(op_s2_reg[4]);
            side_next.yaw_x = 17'(op_s2_reg[5]);
        end
        else
        begin
            side_next.yaw_y = 17'(op_s2_reg[2]);
            side_next.yaw_x = 17'(op_s2_reg[3]);
        end
    end

    rpy_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (radicand_reg),
        .root     (root)
    );

    // side data and flags held in step with the long units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side_next;
            for (int i = 1; i <= ISQ_STEPS; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
            gim_dly_reg[0] <= sd.gimbal;
            for (int i = 1; i < COR_LAT; i++)
            begin
                gim_dly_reg[i] <= gim_dly_reg[i-1];
            end
            rig_dly_reg[0] <= rigid;
            for (int i = 1; i < CORE_LAT - RIG_LAT; i++)
            begin
                rig_dly_reg[i] <= rig_dly_reg[i-1];
            end
            tr_dly_reg[0] <= s_tdata[9*ROT_W +: 3*TRANS_W];
            for (int i = 1; i < CORE_LAT; i++)
            begin
                tr_dly_reg[i] <= tr_dly_reg[i-1];
            end
        end
    end

    assign sd = side_dly_reg[ISQ_STEPS];

    rpy_cordic u_cordic_pitch (
        .clk      (clk),
        .en       (en),
        .half_lim (1'b1),
        .y_in     (CW'(sd.pitch_s) <<< 14),
        .x_in     (CW'(root)),
        .angle    (pitch_c)
    );

    rpy_cordic u_cordic_roll (
        .clk      (clk),
        .en       (en),
        .half_lim (1'b0),
        .y_in     (CW'(sd.roll_y) <<< 14),
        .x_in     (CW'(sd.roll_x) <<< 14),
        .angle    (roll_c)
    );

    rpy_cordic u_cordic_yaw (
        .clk      (clk),
        .en       (en),
        .half_lim (1'b0),
        .y_in     (CW'(sd.yaw_y) <<< 14),
        .x_in     (CW'(sd.yaw_x) <<< 14),
        .angle    (yaw_c)
    );

    assign rig_last = rig_dly_reg[CORE_LAT-RIG_LAT-1];
    assign gim_last = gim_dly_reg[COR_LAT-1];

    // output register: drop the angles of a matrix that is not rigid and the roll at gimbal lock
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_out_reg   <= (rig_last && !gim_last) ? roll_c : '0;
            pitch_out_reg  <= rig_last ? pitch_c[PITCH_W-1:0] : '0;
            yaw_out_reg    <= rig_last ? yaw_c : '0;
            tr_out_reg     <= tr_dly_reg[CORE_LAT-1];
            status_out_reg <= !rig_last;
        end
    end

    assign m_tdata = {1'b0, tr_out_reg, yaw_out_reg, pitch_out_reg, roll_out_reg};
    assign m_tuser = status_out_reg;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (roll_out_reg == '0 && pitch_out_reg == '0
                                   && yaw_out_reg == '0))
        else $error("angles not zero on a non-rigid result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pitch_out_reg >= -15'sd12868 && pitch_out_reg <= 15'sd12868))
        else $error("pitch outside half-pi range");

    a_gimbal_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[CORE_LAT-1] && gim_last) |=> (roll_out_reg == '0))
        else $error("roll not zero at gimbal lock");
`endif

endmodule

// ===== bench/rpy_checker.sv =====
// Checker for the roll/pitch/yaw core: predicts each pose result and compares it.
`timescale 1ns / 1ps

module rpy_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rpy_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rpy_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rpy_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpy_pkg::TOL_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            poses_seen,
    output int                            unrigid_seen,
    output int                            gimbal_seen
);
    import rpy_pkg::*;

    typedef struct packed {
        logic        status;
        logic [M_DATA_W-1:0] data;
    } euler_result_t;

    euler_result_t euler_queue[$];
    logic [TOL_W-1:0] det_tol, ortho_tol, gimbal_thr;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_q24(int i);
        longint tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                            131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI_Q24;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI_Q24;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_q24(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_q24(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(longint z, longint lim);
        longint v;
        v = floor_shift(z + 1024, 11);
        return v < -lim ? -lim : (v > lim ? lim : v);
    endfunction

    function automatic longint floor_root(longint unsigned n);
        longint unsigned root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= root + bit_v)
            begin
                n -= root + bit_v;
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic euler_result_t predict_pose(logic [S_DATA_W-1:0] pose,
                                                   output bit locked);
        euler_result_t res;
        longint r[3][3];
        longint roll, pitch, yaw, det, dev, m, s, c;
        longint unsigned mag, sum, rem;
        bit rigid;
        roll = 0; pitch = 0; yaw = 0; rigid = 1; sum = 0; locked = 0;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                r[a][b] = longint'($signed(pose[(a*3+b)*16 +: 16]));
        det = r[0][0] * (r[1][1] * r[2][2] - r[1][2] * r[2][1])
            - r[0][1] * (r[1][0] * r[2][2] - r[1][2] * r[2][0])
            + r[0][2] * (r[1][0] * r[2][1] - r[1][1] * r[2][0]);
        dev = det - (64'sd1 <<< 42);
        mag = dev < 0 ? -dev : dev;
        if (mag > (longint'(det_tol) << 28))
            rigid = 0;
        for (int a = 0; a < 3 && rigid; a++)
            for (int b = 0; b < 3 && rigid; b++)
            begin
                m = 0;
                for (int k = 0; k < 3; k++)
                    m += r[k][a] * r[k][b];
                if (a == b)
                    m -= 64'sd1 <<< 28;
                mag = m < 0 ? -m : m;
                if (mag >= (64'd1 << 30))
                    rigid = 0;
                else
                    sum += mag * mag;
            end
        if (rigid && sum > (longint'(ortho_tol) << 42))
            rigid = 0;
        if (rigid)
        begin
            s = -r[2][0];
            s = s < -ONE_Q14 ? -ONE_Q14 : (s > ONE_Q14 ? ONE_Q14 : s);
            rem = (64'd1 << 28) - longint'(s * s);
            c = floor_root(rem << 28);
            pitch = round_q13(vector_angle(s * ONE_Q14, c), HALF_PI_Q13);
            if (rem > longint'(gimbal_thr) * longint'(gimbal_thr))
            begin
                roll = round_q13(vector_angle(r[2][1] * ONE_Q14, r[2][2] * ONE_Q14), PI_Q13);
                yaw = round_q13(vector_angle(r[1][0] * ONE_Q14, r[0][0] * ONE_Q14), PI_Q13);
            end
            else
            begin
                locked = 1;
                yaw = round_q13(vector_angle(-r[0][1] * ONE_Q14, r[1][1] * ONE_Q14), PI_Q13);
            end
        end
        res.status = !rigid;
        res.data = {1'b0, pose[144 +: 96], yaw[15:0], pitch[14:0], roll[15:0]};
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        euler_result_t exp_r, got;
        bit locked;
        if (!rst_n)
        begin
            det_tol    <= 15'd2;
            ortho_tol  <= 15'd2;
            gimbal_thr <= 15'd1;
            euler_queue.delete();
            fail_count <= 0;
            pending <= 0;
            poses_seen <= 0;
            unrigid_seen <= 0;
            gimbal_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DET_TOL:    det_tol <= cfg_data;
                    REG_ORTHO_TOL:  ortho_tol <= cfg_data;
                    REG_GIMBAL_THR: gimbal_thr <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                exp_r = predict_pose(s_tdata, locked);
                euler_queue.push_back(exp_r);
                poses_seen <= poses_seen + 1;
                unrigid_seen <= unrigid_seen + exp_r.status;
                gimbal_seen <= gimbal_seen + locked;
            end
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.data = m_tdata;
                if (euler_queue.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0b data %h", $time, m_tuser,
                             m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = euler_queue.pop_front();
                    if (exp_r.data[15:0] !== got.data[15:0]
                        || exp_r.data[30:16] !== got.data[30:16]
                        || exp_r.data[46:31] !== got.data[46:31]
                        || exp_r.data[143:47] !== got.data[143:47]
                        || exp_r.status !== got.status)
                    begin
                        $display("%0t: mismatch roll/pitch/yaw/trans/status expected %h %h %h %h %b",
                                 $time, exp_r.data[15:0], exp_r.data[30:16],
                                 exp_r.data[46:31], exp_r.data[142:47], exp_r.status);
                        $display("%0t:          actual                             %h %h %h %h %b",
                                 $time, got.data[15:0], got.data[30:16],
                                 got.data[46:31], got.data[142:47], got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= euler_queue.size();
        end
    end

endmodule

// ===== bench/tb_rotation_to_roll_pitch_yaw_core.sv =====
// Testbench top for the roll/pitch/yaw core: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_rotation_to_roll_pitch_yaw_core;
    import rpy_pkg::*;

    localparam int ONE = 16384;
    localparam int WATCHDOG = 20000;

    logic clk = 0, rst_n = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0, m_tuser;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TOL_W-1:0] cfg_data = '0;
    int fail_count, pending, poses_seen, unrigid_seen, gimbal_seen;
    int send_idle_pct = 20, recv_idle_pct = 56;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    rotation_to_roll_pitch_yaw_core dut (.*);

    rpy_checker checker_i (.*);

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("** rotation_to_roll_pitch_yaw_core: FAILED **");
            $finish;
        end
    end

    // hold tvalid high across back-to-back transfers; drop it only while idling
    task automatic send_pose(logic [8:0][15:0] rot, logic [2:0][31:0] trans);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {trans, rot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [2:0][31:0] rand_trans();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // random axis-angle-ish pose built from three elementary rotations, plus noise
    task automatic send_rotation(int noise, bit force_lock);
        real a, b, g, m[3][3], ca, sa, cb, sb, cg, sg;
        logic [8:0][15:0] rot;
        a = ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159;
        b = ($urandom_range(20000) / 10000.0 - 1.0) * 1.5708;
        g = ($urandom_range(20000) / 10000.0 - 1.0) * 3.14159;
        if (force_lock)
            b = $urandom_range(1) ? 1.5708 : -1.5708;
        ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b); cg = $cos(g); sg = $sin(g);
        m[0][0] = cg*cb; m[0][1] = cg*sb*sa - sg*ca; m[0][2] = cg*sb*ca + sg*sa;
        m[1][0] = sg*cb; m[1][1] = sg*sb*sa + cg*ca; m[1][2] = sg*sb*ca - cg*sa;
        m[2][0] = -sb;   m[2][1] = cb*sa;            m[2][2] = cb*ca;
        for (int i = 0; i < 9; i++)
            rot[i] = 16'($rtoi(m[i/3][i%3] * ONE)) + 16'($urandom_range(2*noise) - noise);
        send_pose(rot, rand_trans());
    endtask

    task automatic random_phase(int count);
        logic [8:0][15:0] rot;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0:       begin
                             for (int i = 0; i < 9; i++) rot[i] = $urandom();
                             send_pose(rot, rand_trans());
                         end
                1:       send_rotation(0, 1);
                2:       send_rotation($urandom_range(400), 0);
                default: send_rotation($urandom_range(2), 0);
            endcase
        end
    endtask

    initial
    begin
        logic [8:0][15:0] rot;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity, axis swaps, gimbal lock, extremes, zero matrix
        rot = {16'(ONE), 16'd0, 16'd0, 16'd0, 16'(ONE), 16'd0, 16'd0, 16'd0, 16'(ONE)};
        send_pose(rot, {32'h7fffffff, 32'h80000000, 32'hffffffff});
        rot = {16'(-ONE), 16'd0, 16'd0, 16'd0, 16'(-ONE), 16'd0, 16'd0, 16'd0, 16'(ONE)};
        send_pose(rot, {32'h0, 32'h1, 32'h55555555});
        rot = {16'(ONE), 16'd0, 16'd0, 16'd0, 16'(ONE), 16'd0, 16'd0, 16'd0, 16'(-ONE)};
        send_pose(rot, {32'haaaaaaaa, 32'h0, 32'h0});
        // pitch +90 and -90: gimbal branch
        rot = {16'd0, 16'd0, 16'(-ONE), 16'd0, 16'(ONE), 16'd0, 16'(ONE), 16'd0, 16'd0};
        send_pose(rot, rand_trans());
        rot = {16'd0, 16'd0, 16'(ONE), 16'd0, 16'(ONE), 16'd0, 16'(-ONE), 16'd0, 16'd0};
        send_pose(rot, rand_trans());
        rot = {16'd0, 16'(ONE), 16'd0, 16'(-ONE), 16'd0, 16'd0, 16'd0, 16'd0, 16'(ONE)};
        send_pose(rot, rand_trans());
        send_pose('0, rand_trans());
        send_pose({9{16'h7fff}}, rand_trans());
        send_pose({9{16'h8000}}, rand_trans());
        send_pose({9{16'hffff}}, rand_trans());
        send_pose({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                   16'h8000, 16'h7fff, 16'h8000}, rand_trans());
        for (int i = 0; i < 6; i++)
            send_rotation(0, i[0]);
        drain_pipe();

        write_reg(REG_DET_TOL, 15'd16384);
        write_reg(REG_ORTHO_TOL, 15'd16384);
        write_reg(REG_GIMBAL_THR, 15'd16384);
        write_reg(2'd3, 15'h7fff);
        random_phase(150);
        drain_pipe();

        write_reg(REG_DET_TOL, 15'd0);
        write_reg(REG_ORTHO_TOL, 15'd0);
        write_reg(REG_GIMBAL_THR, 15'd0);
        random_phase(100);
        drain_pipe();

        write_reg(REG_DET_TOL, 15'h7fff);
        write_reg(REG_ORTHO_TOL, 15'h7fff);
        write_reg(REG_GIMBAL_THR, 15'd200);
        random_phase(150);
        drain_pipe();

        send_idle_pct = 56;
        recv_idle_pct = 20;
        write_reg(REG_DET_TOL, 15'd40);
        write_reg(REG_ORTHO_TOL, 15'd60);
        write_reg(REG_GIMBAL_THR, 15'd16);
        random_phase(250);
        drain_pipe();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_DET_TOL, 15'd2);
        write_reg(REG_ORTHO_TOL, 15'd2);
        write_reg(REG_GIMBAL_THR, 15'd1);
        random_phase(230);
        drain_pipe();

        $display("covered %0d poses: %0d not rigid, %0d on the gimbal-lock branch,",
                 poses_seen, unrigid_seen, gimbal_seen);
        $display("over five tolerance settings and three handshake pacing phases");
        if (fail_count == 0)
            $display("** rotation_to_roll_pitch_yaw_core: PASSED **");
        else
            $display("** rotation_to_roll_pitch_yaw_core: FAILED **");
        $finish;
    end

endmodule
